// ===== hw/rtl/wblc_pkg.sv =====
`timescale 1ns / 1ps

package wblc_pkg;

  // Fixed payload widths of the request and response channels
  localparam int MODE_W = 1;
  localparam int ADDR_W = 32;
  localparam int BYTE_W = 8;
  localparam int LINE_W = 64;

  // Access kinds
  localparam logic [MODE_W-1:0] MODE_READ  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 1'b1;

  // Line status codes
  typedef enum logic [1:0] {
    ST_INVALID = 2'd0,
    ST_CLEAN   = 2'd1,
    ST_DIRTY   = 2'd2
  } status_t;

endpackage

// ===== hw/rtl/wblc_ifs.sv =====
`timescale 1ns / 1ps

// Request channel: one byte access per transaction
interface wblc_req_if
  import wblc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ADDR_W-1:0] address;
  logic [BYTE_W-1:0] write_data;
  logic [LINE_W-1:0] fill_line;

  modport source (output valid, mode, address, write_data, fill_line, input ready);
  modport sink   (input valid, mode, address, write_data, fill_line, output ready);
endinterface

// Response channel: one result per access
interface wblc_rsp_if
  import wblc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_data;
  logic              hit;
  logic              writeback_valid;
  logic [ADDR_W-1:0] writeback_address;
  logic [LINE_W-1:0] writeback_line;

  modport source (output valid, read_data, hit, writeback_valid, writeback_address,
                  writeback_line, input ready);
  modport sink   (input valid, read_data, hit, writeback_valid, writeback_address,
                  writeback_line, output ready);
endinterface

// ===== hw/rtl/write_back_lru_cache_unit.sv =====
`timescale 1ns / 1ps

// Set-associative, write-back, write-allocate byte cache with saturating
// age-counter LRU. Each request transaction is one byte read or write; the
// memory side supplies the addressed line on fill_line with every access,
// and a dirty victim leaves on the response as writeback_address and
// writeback_line. Tag, status and age of a set sit in one row of a
// synchronous metadata memory, the line bytes in one row of a data memory;
// each access reads both rows, updates them and writes them back. A new
// transaction is accepted only once the last one has finished the update
// and write-back, and only while the response register is free or being
// drained. After reset the block clears the metadata memory, one set per
// cycle, and accepts no request then.
module write_back_lru_cache_unit
  import wblc_pkg::*;
#(
  parameter int WAYS        = 4,
  parameter int INDEX_BITS  = 6,
  parameter int OFFSET_BITS = 3,
  parameter int ADDR_BITS   = 32,
  parameter int AGE_BITS    = 16
) (
  input  logic       clk,
  input  logic       rst,
  wblc_req_if.sink   req,
  wblc_rsp_if.source rsp
);

  localparam int SETS       = 1 << INDEX_BITS;
  localparam int TAG_BITS   = ADDR_BITS - OFFSET_BITS - INDEX_BITS;
  localparam int LINE_BYTES = 1 << OFFSET_BITS;
  localparam int LINE_BITS  = 8 * LINE_BYTES;
  localparam int OFF_W      = (OFFSET_BITS > 0) ? OFFSET_BITS : 1;
  localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP
  } state_t;

  typedef logic [WAYS-1:0][TAG_BITS-1:0]          tag_row_t;
  typedef logic [WAYS-1:0][$bits(status_t)-1:0]   stat_row_t;
  typedef logic [WAYS-1:0][AGE_BITS-1:0]          age_row_t;
  typedef logic [WAYS-1:0][LINE_BITS-1:0]         data_row_t;

  typedef struct packed {
    tag_row_t  tag;
    stat_row_t stat;
    age_row_t  age;
  } meta_row_t;

  // Set memories
  meta_row_t meta_mem [SETS];
  data_row_t data_mem [SETS];

  state_t                state;
  logic [INDEX_BITS-1:0] clr_idx;

  // Captured request
  logic [MODE_W-1:0]     req_mode;
  logic [TAG_BITS-1:0]   req_tag;
  logic [INDEX_BITS-1:0] req_set;
  logic [OFF_W-1:0]      req_off;
  logic [BYTE_W-1:0]     req_wdata;
  logic [LINE_BITS-1:0]  req_fill;

  // Read rows
  tag_row_t  rd_tag;
  stat_row_t rd_stat;
  age_row_t  rd_age;
  data_row_t rd_data;

  // Address split of the incoming request
  logic [ADDR_BITS-1:0]  in_ea;
  logic [INDEX_BITS-1:0] in_set;
  logic                  in_acc;

  // Lookup results
  age_row_t              age_inc;
  logic [AGE_BITS-1:0]   max_age;
  logic [WAY_W-1:0]      victim;
  logic [WAY_W-1:0]      inv_way;
  logic                  any_inv;
  logic [WAY_W-1:0]      hit_way;
  logic                  hit;
  logic [WAY_W-1:0]      used;
  logic                  wb;
  logic [ADDR_BITS-1:0]  wb_ea;
  logic [LINE_BITS-1:0]  old_line;
  logic [LINE_BITS-1:0]  new_line;
  logic [BYTE_W-1:0]     rbyte;
  tag_row_t              wr_tag;
  stat_row_t             wr_stat;
  age_row_t              wr_age;
  data_row_t             wr_data;

  // Response register
  logic                  out_valid;
  logic [BYTE_W-1:0]     out_rdata;
  logic                  out_hit;
  logic                  out_wb;
  logic [ADDR_W-1:0]     out_wb_addr;
  logic [LINE_W-1:0]     out_wb_line;

  // Cut the address to ADDR_BITS, widening with zeros where needed
  generate
    if (ADDR_BITS >= ADDR_W) begin : g_addr_wide
      assign in_ea = ADDR_BITS'(req.address);
    end else begin : g_addr_narrow
      assign in_ea = req.address[ADDR_BITS-1:0];
    end
  endgenerate

  assign in_set    = INDEX_BITS'(in_ea >> OFFSET_BITS);
  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign in_acc    = req.valid && req.ready;

  // Sequence the clearing pass, the read and the update
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == INDEX_BITS'(SETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // Capture the request and read the set rows
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_mode  <= req.mode;
      req_tag   <= TAG_BITS'(in_ea >> (OFFSET_BITS + INDEX_BITS));
      req_set   <= in_set;
      req_off   <= OFF_W'(in_ea & ADDR_BITS'(LINE_BYTES - 1));
      req_wdata <= req.write_data;
      req_fill  <= req.fill_line[LINE_BITS-1:0];
      rd_tag    <= meta_mem[in_set].tag;
      rd_stat   <= meta_mem[in_set].stat;
      rd_age    <= meta_mem[in_set].age;
      rd_data   <= data_mem[in_set];
    end
  end

  // Age every way, pick the hit way or the victim
  always_comb begin
    max_age = '0;
    victim  = '0;
    inv_way = '0;
    any_inv = 1'b0;
    hit_way = '0;
    hit     = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      age_inc[w] = (rd_age[w] == AGE_MAX) ? rd_age[w] : rd_age[w] + 1'b1;
      if (w == 0 || age_inc[w] > max_age) begin
        victim  = WAY_W'(w);
        max_age = age_inc[w];
      end
      if (rd_stat[w] == ST_INVALID) begin
        inv_way = WAY_W'(w);
        any_inv = 1'b1;
      end
      if (!hit && rd_stat[w] != ST_INVALID && rd_tag[w] == req_tag) begin
        hit_way = WAY_W'(w);
        hit     = 1'b1;
      end
    end
    priority if (hit) begin
      used = hit_way;
    end else if (any_inv) begin
      used = inv_way;
    end else begin
      used = victim;
    end
  end

  // Build the updated rows and the victim's write-back
  always_comb begin
    wb       = !hit && (rd_stat[used] == ST_DIRTY);
    wb_ea    = (ADDR_BITS'(rd_tag[used]) << (OFFSET_BITS + INDEX_BITS)) |
               (ADDR_BITS'(req_set) << OFFSET_BITS);
    old_line = hit ? rd_data[used] : req_fill;
    rbyte    = old_line[req_off*8 +: 8];
    new_line = old_line;
    for (int b = 0; b < LINE_BYTES; b++) begin
      if (req_mode == MODE_WRITE && req_off == OFF_W'(b)) begin
        new_line[b*8 +: 8] = req_wdata;
      end
    end
    wr_tag  = rd_tag;
    wr_stat = rd_stat;
    wr_age  = age_inc;
    wr_data = rd_data;
    wr_tag[used]  = req_tag;
    wr_age[used]  = '0;
    wr_data[used] = new_line;
    if (req_mode == MODE_WRITE) begin
      wr_stat[used] = ST_DIRTY;
    end else if (!hit) begin
      wr_stat[used] = ST_CLEAN;
    end
  end

  // Write back the rows; the clearing pass resets status and age
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      meta_mem[clr_idx] <= '{tag: '0, stat: {WAYS{ST_INVALID}}, age: '0};
    end else if (state == S_LOOKUP) begin
      meta_mem[req_set] <= '{tag: wr_tag, stat: wr_stat, age: wr_age};
      data_mem[req_set] <= wr_data;
    end
  end

  // Load the response register
  always_ff @(posedge clk) begin
    if (state == S_LOOKUP) begin
      out_rdata   <= (req_mode == MODE_WRITE) ? '0 : rbyte;
      out_hit     <= hit;
      out_wb      <= wb;
      out_wb_addr <= wb ? ADDR_W'(wb_ea) : '0;
      out_wb_line <= wb ? LINE_W'(rd_data[used]) : '0;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.read_data         = out_rdata;
  assign rsp.hit               = out_hit;
  assign rsp.writeback_valid   = out_wb;
  assign rsp.writeback_address = out_wb_addr;
  assign rsp.writeback_line    = out_wb_line;

endmodule

// ===== hw/rtl/wblc_checker.sv =====
`timescale 1ns / 1ps

module wblc_checker
  import wblc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              rsp_hit,
  input logic              rsp_wb_valid,
  input logic [ADDR_W-1:0] rsp_wb_addr,
  input logic [LINE_W-1:0] rsp_wb_line
);

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_wb_addr) && $stable(rsp_hit))
    else $error("stalled response changed");

  // Drive zero write-back fields when nothing is evicted
  a_wb_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_wb_valid |-> rsp_wb_addr == '0 && rsp_wb_line == '0)
    else $error("write-back fields set without eviction");

  // Evict only on a miss
  a_wb_miss: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_wb_valid |-> !rsp_hit)
    else $error("write-back on a hit");

  // Drop ready for the cycle after a transaction is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // Deliver the response through the lookup state and the response register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> ##1 rsp_valid)
    else $error("response missing");

endmodule

bind write_back_lru_cache_unit wblc_checker u_wblc_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_hit      (rsp.hit),
  .rsp_wb_valid (rsp.writeback_valid),
  .rsp_wb_addr  (rsp.writeback_address),
  .rsp_wb_line  (rsp.writeback_line)
);

// ===== tb/sv/write_back_lru_cache_unit_tb.sv =====
`timescale 1ns / 1ps

module write_back_lru_cache_unit_tb;
  import wblc_pkg::*;

  localparam int WAYS        = 4;
  localparam int INDEX_BITS  = 6;
  localparam int OFFSET_BITS = 3;
  localparam int AGE_BITS    = 16;
  localparam int TAG_W       = ADDR_W - INDEX_BITS - OFFSET_BITS;
  localparam int SETS        = 1 << INDEX_BITS;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_PRINTED = 50;
  localparam int AGE_SET     = 12;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              hit;
    logic              writeback_valid;
    logic [ADDR_W-1:0] writeback_address;
    logic [LINE_W-1:0] writeback_line;
  } access_result_t;

  // Shadow copy of the cache contents and the responses still owed
  class cache_shadow;
    status_t            line_state [SETS][WAYS];
    logic [TAG_W-1:0]   line_tag   [SETS][WAYS];
    logic [LINE_W-1:0]  line_data  [SETS][WAYS];
    logic [AGE_BITS-1:0] line_age  [SETS][WAYS];
    access_result_t     expected_results [$];
    int                 mismatches;

    function void clear_state();
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          line_state[s][w] = ST_INVALID;
          line_tag[s][w]   = '0;
          line_data[s][w]  = '0;
          line_age[s][w]   = '0;
        end
      end
      expected_results.delete();
      mismatches = 0;
    endfunction

    // Work out the response of one accepted access and update the contents
    function void note_access(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr,
                              logic [BYTE_W-1:0] wdata, logic [LINE_W-1:0] fill);
      logic [OFFSET_BITS-1:0] ofs;
      logic [INDEX_BITS-1:0]  set_idx;
      logic [TAG_W-1:0]       tag;
      logic [AGE_BITS-1:0]    oldest;
      int                     victim;
      int                     free_way;
      int                     way_used;
      access_result_t         res;
      ofs      = addr[OFFSET_BITS-1:0];
      set_idx  = addr[OFFSET_BITS +: INDEX_BITS];
      tag      = addr[ADDR_W-1 -: TAG_W];
      res      = '0;
      victim   = 0;
      free_way = -1;
      way_used = -1;
      oldest   = '0;
      // Age every way of the set, saturating, and find the oldest and last free way
      for (int w = 0; w < WAYS; w++) begin
        if (line_age[set_idx][w] != '1) line_age[set_idx][w]++;
        if (w == 0 || line_age[set_idx][w] > oldest) begin
          victim = w;
          oldest = line_age[set_idx][w];
        end
        if (line_state[set_idx][w] == ST_INVALID) free_way = w;
      end
      // Look for the first matching valid way
      for (int w = 0; w < WAYS; w++) begin
        if (way_used < 0 && line_state[set_idx][w] != ST_INVALID &&
            line_tag[set_idx][w] == tag) way_used = w;
      end
      if (way_used >= 0) begin
        res.hit = 1'b1;
      end else begin
        way_used = (free_way >= 0) ? free_way : victim;
        // Evict the victim, writing it back to its own line address if dirty
        if (line_state[set_idx][way_used] == ST_DIRTY) begin
          res.writeback_valid   = 1'b1;
          res.writeback_address = {line_tag[set_idx][way_used], set_idx,
                                   {OFFSET_BITS{1'b0}}};
          res.writeback_line    = line_data[set_idx][way_used];
        end
        line_data[set_idx][way_used]  = fill;
        line_tag[set_idx][way_used]   = tag;
        line_state[set_idx][way_used] = ST_CLEAN;
      end
      line_age[set_idx][way_used] = '0;
      if (mode == MODE_WRITE) begin
        line_data[set_idx][way_used][ofs*8 +: 8] = wdata;
        line_state[set_idx][way_used] = ST_DIRTY;
      end else begin
        res.read_data = line_data[set_idx][way_used][ofs*8 +: 8];
      end
      expected_results.push_back(res);
    endfunction

    task report_mismatch(string what, logic [LINE_W-1:0] got, logic [LINE_W-1:0] want);
      if (mismatches < MAX_PRINTED)
        $display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
      mismatches++;
    endtask

    // Compare one response with the oldest outstanding expectation
    task check_result(access_result_t got);
      access_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("response with no access outstanding", LINE_W'(got.read_data), '0);
        return;
      end
      want = expected_results.pop_front();
      if (got.read_data !== want.read_data)
        report_mismatch("read_data", LINE_W'(got.read_data), LINE_W'(want.read_data));
      if (got.hit !== want.hit)
        report_mismatch("hit", LINE_W'(got.hit), LINE_W'(want.hit));
      if (got.writeback_valid !== want.writeback_valid)
        report_mismatch("writeback_valid", LINE_W'(got.writeback_valid),
                        LINE_W'(want.writeback_valid));
      if (got.writeback_address !== want.writeback_address)
        report_mismatch("writeback_address", LINE_W'(got.writeback_address),
                        LINE_W'(want.writeback_address));
      if (got.writeback_line !== want.writeback_line)
        report_mismatch("writeback_line", got.writeback_line, want.writeback_line);
    endtask

    task report_leftovers();
      access_result_t want;
      while (expected_results.size() > 0) begin
        want = expected_results.pop_front();
        report_mismatch("response never arrived, read_data", 'x, LINE_W'(want.read_data));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   quiet_cycles  = 0;
  cache_shadow shadow;

  wblc_req_if req_ch ();
  wblc_rsp_if rsp_ch ();

  write_back_lru_cache_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #1 clk = ~clk;

  // Observe both channels and keep the shadow in step
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        shadow.note_access(req_ch.mode, req_ch.address, req_ch.write_data,
                           req_ch.fill_line);
      if (rsp_ch.valid && rsp_ch.ready)
        shadow.check_result('{rsp_ch.read_data, rsp_ch.hit, rsp_ch.writeback_valid,
                              rsp_ch.writeback_address, rsp_ch.writeback_line});
    end
  end

  // Stall the response side at random
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [ADDR_W-1:0] line_addr(int tag, int set_idx, int ofs);
    return {TAG_W'(tag), INDEX_BITS'(set_idx), OFFSET_BITS'(ofs)};
  endfunction

  // Offer one access and hold it until the transaction completes
  task automatic send_access(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr,
                             logic [BYTE_W-1:0] wdata, logic [LINE_W-1:0] fill);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= mode;
    req_ch.address    <= addr;
    req_ch.write_data <= wdata;
    req_ch.fill_line  <= fill;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic read_at(logic [ADDR_W-1:0] addr);
    send_access(MODE_READ, addr, BYTE_W'($urandom), {$urandom, $urandom});
  endtask

  // Extremes of the address and data, dirty and clean eviction, hit on a later way
  task automatic run_directed();
    send_access(MODE_READ, '0, 8'h5a, '1);
    send_access(MODE_WRITE, '1, 8'h00, '0);
    read_at('1);
    read_at(32'hffff_fff8);
    send_access(MODE_WRITE, 32'hffff_fff8, 8'hff, '1);
    for (int t = 1; t <= 4; t++)
      send_access(MODE_WRITE, line_addr(t, 1, t), BYTE_W'($urandom),
                  {$urandom, $urandom});
    read_at(line_addr(2, 1, 2));
    read_at(line_addr(5, 1, 0));
    read_at(line_addr(1, 1, 1));
    send_access(MODE_WRITE, line_addr(6, 1, 7), 8'hff, '0);
    for (int t = 1; t <= 5; t++)
      read_at(line_addr(t, 2, 3));
    read_at(line_addr(1, 2, 3));
  endtask

  // Keep hitting one way so the other ways of the set grow old,
  // then check that a miss evicts the first of the oldest
  task automatic run_lru_order();
    for (int t = 16; t < 20; t++)
      read_at(line_addr(t, AGE_SET, 0));
    for (int n = 0; n < 8; n++)
      read_at(line_addr(19, AGE_SET, n));
    send_access(MODE_WRITE, line_addr(20, AGE_SET, 5), BYTE_W'($urandom),
                {$urandom, $urandom});
    read_at(line_addr(16, AGE_SET, 2));
    read_at(line_addr(17, AGE_SET, 2));
  endtask

  // Random accesses drawn mostly from a few busy sets and a small tag pool
  task automatic run_random(int count);
    logic [TAG_W-1:0]       tag_pool [6];
    logic [INDEX_BITS-1:0]  busy_sets [3];
    logic [TAG_W-1:0]       tag;
    logic [INDEX_BITS-1:0]  set_idx;
    logic [MODE_W-1:0]      mode;
    foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom);
    foreach (busy_sets[i]) busy_sets[i] = INDEX_BITS'($urandom);
    for (int n = 0; n < count; n++) begin
      set_idx = ($urandom_range(99) < 70) ? busy_sets[$urandom_range(2)]
                                          : INDEX_BITS'($urandom);
      tag  = ($urandom_range(99) < 80) ? tag_pool[$urandom_range(5)] : TAG_W'($urandom);
      mode = $urandom_range(1) ? MODE_WRITE : MODE_READ;
      send_access(mode, {tag, set_idx, OFFSET_BITS'($urandom)}, BYTE_W'($urandom),
                  {$urandom, $urandom});
    end
  endtask

  initial begin
    shadow = new;
    shadow.clear_state();
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.mode       <= MODE_READ;
    req_ch.address    <= '0;
    req_ch.write_data <= '0;
    req_ch.fill_line  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 33;
    recv_idle_pct = 45;
    run_directed();
    run_lru_order();
    run_random(380);
    send_idle_pct = 45;
    recv_idle_pct = 33;
    run_random(380);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(390);
    req_ch.valid <= 1'b0;

    // Drain outstanding responses, then let the pipeline settle
    while (shadow.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    shadow.report_leftovers();
    if (shadow.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
